/* src/ufwm_pkg.sv */
// ufwm_pkg: shared sizes, payload structs and state codes for the
// union-find wall merger. No dependencies.
package ufwm_pkg;

  localparam int CELLS  = 1024;
  localparam int CELL_W = $clog2(CELLS);
  localparam int RANK_W = 4;
  localparam int CNT_W  = 11;
  localparam int WALL_W = 11;

  localparam logic [RANK_W-1:0] RANK_MAX       = 4'd15;
  localparam logic [CNT_W-1:0]  CELL_COUNT_RST = 11'd1024;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_WALL  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WALL_W-1:0] wall_id;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
  } in_t;

  typedef struct packed {
    logic [WALL_W-1:0] wall_echo;
    logic              removed;
    logic              bad_cell;
  } out_t;

  // finished item from the engine to the output register
  typedef struct packed {
    logic valid;
    out_t res;
  } fin_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_INIT   = 8'b0000_0010,
    ST_CLEAR  = 8'b0000_0100,
    ST_FIND   = 8'b0000_1000,
    ST_COMP   = 8'b0001_0000,
    ST_RANK_A = 8'b0010_0000,
    ST_RANK_B = 8'b0100_0000,
    ST_LINK   = 8'b1000_0000
  } state_t;

endpackage

/* src/ufwm_ram.sv */
// ufwm_ram: generic simple dual-port RAM, one write and one registered read port.
// A read of the address being written returns the new data. No dependencies.
module ufwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/ufwm_engine.sv */
// ufwm_engine: sequencer for root search, path compression, link by rank and
// set clearing over the parent and rank memories. Uses ufwm_pkg and ufwm_ram.
module ufwm_engine
  import ufwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_t              in_data,
  input  logic [CNT_W-1:0] cells_used,
  output logic             busy,
  output fin_t             fin
);

  state_t            state_r, state_nxt;
  logic [CELL_W-1:0] cnt_r, cnt_nxt;
  logic [CELL_W-1:0] cur_r, cur_nxt;
  logic [CELL_W-1:0] root_a_r, root_a_nxt;
  logic [CELL_W-1:0] root_b_r, root_b_nxt;
  logic              sel_r, sel_nxt;
  logic [RANK_W-1:0] rank_a_r, rank_a_nxt;
  in_t               item_r, item_nxt;

  logic              p_we;
  logic [CELL_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic              r_we;
  logic [CELL_W-1:0] r_waddr, r_raddr;
  logic [RANK_W-1:0] r_wdata, r_rdata;

  logic [CNT_W-1:0]  last_cell;
  logic [CELL_W-1:0] root_cur;
  logic [CELL_W-1:0] start_cell;
  logic              bad;

  assign last_cell  = cells_used - CNT_W'(1);
  assign root_cur   = sel_r ? root_b_r : root_a_r;
  assign start_cell = sel_r ? item_r.cell_b : item_r.cell_a;
  assign bad        = (CNT_W'(in_data.cell_a) >= cells_used) ||
                      (CNT_W'(in_data.cell_b) >= cells_used);
  assign busy       = (state_r != ST_IDLE);

  ufwm_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  ufwm_ram #(.WIDTH(RANK_W), .DEPTH(CELLS)) u_rank (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    root_a_nxt = root_a_r;
    root_b_nxt = root_b_r;
    sel_nxt    = sel_r;
    rank_a_nxt = rank_a_r;
    item_nxt   = item_r;
    p_we       = 1'b0;
    p_waddr    = cur_r;
    p_wdata    = root_cur;
    p_raddr    = cur_r;
    r_we       = 1'b0;
    r_waddr    = cnt_r;
    r_wdata    = '0;
    r_raddr    = root_a_r;
    fin        = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          if (in_data.kind == KIND_START) begin
            cnt_nxt = '0;
            if (cells_used == '0) begin
              fin.valid = 1'b1;
            end else begin
              state_nxt = ST_CLEAR;
            end
          end else if (bad) begin
            fin.valid         = 1'b1;
            fin.res.wall_echo = in_data.wall_id;
            fin.res.bad_cell  = 1'b1;
          end else begin
            sel_nxt   = 1'b0;
            cur_nxt   = in_data.cell_a;
            p_raddr   = in_data.cell_a;
            state_nxt = ST_FIND;
          end
        end
      end

      ST_INIT, ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = cnt_r;
        p_wdata = cnt_r;
        r_we    = 1'b1;
        r_waddr = cnt_r;
        cnt_nxt = cnt_r + CELL_W'(1);
        if (state_r == ST_INIT) begin
          if (cnt_r == CELL_W'(CELLS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end else if (cnt_r == last_cell[CELL_W-1:0]) begin
          cnt_nxt   = '0;
          fin.valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_FIND: begin
        if (p_rdata == cur_r) begin
          if (sel_r) begin
            root_b_nxt = cur_r;
          end else begin
            root_a_nxt = cur_r;
          end
          if (start_cell != cur_r) begin
            // second pass over the path from the start cell
            cur_nxt   = start_cell;
            p_raddr   = start_cell;
            state_nxt = ST_COMP;
          end else if (!sel_r) begin
            sel_nxt   = 1'b1;
            cur_nxt   = item_r.cell_b;
            p_raddr   = item_r.cell_b;
            state_nxt = ST_FIND;
          end else begin
            state_nxt = ST_RANK_A;
          end
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end

      ST_COMP: begin
        // point this node at the root while fetching its old parent
        p_we = 1'b1;
        if (p_rdata != root_cur) begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end else if (!sel_r) begin
          sel_nxt   = 1'b1;
          cur_nxt   = item_r.cell_b;
          p_raddr   = item_r.cell_b;
          state_nxt = ST_FIND;
        end else begin
          state_nxt = ST_RANK_A;
        end
      end

      ST_RANK_A: begin
        // rank of root a is read here, root b follows in the next cycle
        if (root_a_r == root_b_r) begin
          fin.valid         = 1'b1;
          fin.res.wall_echo = item_r.wall_id;
          state_nxt         = ST_IDLE;
        end else begin
          state_nxt = ST_RANK_B;
        end
      end

      ST_RANK_B: begin
        rank_a_nxt = r_rdata;
        r_raddr    = root_b_r;
        state_nxt  = ST_LINK;
      end

      ST_LINK: begin
        p_we = 1'b1;
        if (rank_a_r > r_rdata) begin
          p_waddr = root_b_r;
          p_wdata = root_a_r;
        end else begin
          p_waddr = root_a_r;
          p_wdata = root_b_r;
          if ((rank_a_r == r_rdata) && (r_rdata != RANK_MAX)) begin
            r_we    = 1'b1;
            r_waddr = root_b_r;
            r_wdata = r_rdata + RANK_W'(1);
          end
        end
        fin.valid         = 1'b1;
        fin.res.wall_echo = item_r.wall_id;
        fin.res.removed   = 1'b1;
        state_nxt         = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    root_a_r <= root_a_nxt;
    root_b_r <= root_b_nxt;
    rank_a_r <= rank_a_nxt;
    item_r   <= item_nxt;
  end

endmodule

/* src/union_find_wall_merger.sv */
// union_find_wall_merger: top level with the cell count register and the
// result register. Uses ufwm_pkg and ufwm_engine.

// Disjoint-set engine for maze carving: one wall item per transfer, one result
// per item, shown on out_data for exactly one cycle with out_valid high; the
// receiver cannot stall, so it must take every result. After reset the block
// holds busy high while it sets every cell to its own set. A start item
// (kind 0) clears the cells in use, n = min(cell_count, 1024). A wall item that
// joins two sets walks the paths from its two cells to their roots: each step
// of the root search and of the compression pass is one access of the
// single-read-port parent memory, and the link by rank reads and writes the
// rank memory in ST_RANK_A, ST_RANK_B and ST_LINK. A wall whose cells already
// share a set ends in ST_RANK_A, without ST_RANK_B and the link. With path
// compression the paths stay short. A bad cell index finishes at once. For an
// item that raises busy, the result appears in the same cycle in which busy
// falls, and a new item may be started in that cycle.
module union_find_wall_merger
  import ufwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] cell_count_r;
  logic [CNT_W-1:0] cells_used;
  logic             out_valid_r;
  out_t             out_data_r;
  fin_t             fin;

  // counts above the store size are clamped
  assign cells_used = (cell_count_r > CNT_W'(CELLS)) ? CNT_W'(CELLS) : cell_count_r;

  ufwm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .cells_used (cells_used),
    .busy       (busy),
    .fin        (fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= CELL_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cell_count_r <= cfg_wdata;
      end
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      out_data_r <= fin.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* dv/ufwm_checker.sv */
// ufwm_checker: watches the item, result and cell count ports of the union-find
// wall merger, predicts every result and compares it with what the block shows.
// Depends on ufwm_pkg for the payload structs, sizes and item kinds.
module ufwm_checker
  import ufwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_t              in_data,
  input  logic             out_valid,
  input  out_t             out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CELL_W-1:0] parent_mem [CELLS];
  logic [RANK_W-1:0] rank_mem   [CELLS];
  logic [CNT_W-1:0]  cells_used;

  out_t expected_results [$];
  int   errs    = 0;
  int   checked = 0;

  assign fail_count = errs;

  function automatic void clear_sets(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      parent_mem[i] = CELL_W'(i);
      rank_mem[i]   = '0;
    end
  endfunction

  // root search followed by a second pass that points the path at the root
  function automatic logic [CELL_W-1:0] root_of(input logic [CELL_W-1:0] node);
    logic [CELL_W-1:0] r;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] nx;
    int steps;
    r = node;
    steps = 0;
    while (steps < CELLS && parent_mem[r] != r) begin
      r = parent_mem[r];
      steps++;
    end
    x = node;
    steps = 0;
    while (steps < CELLS && x != r) begin
      nx = parent_mem[x];
      parent_mem[x] = r;
      x = nx;
      steps++;
    end
    return r;
  endfunction

  function automatic out_t predict_merge(input in_t item);
    out_t res;
    int n;
    logic [CELL_W-1:0] ra;
    logic [CELL_W-1:0] rb;
    n = (int'(cells_used) < CELLS) ? int'(cells_used) : CELLS;
    res = '0;
    if (item.kind == KIND_START) begin
      clear_sets(n);
      return res;
    end
    res.wall_echo = item.wall_id;
    if (int'(item.cell_a) >= n || int'(item.cell_b) >= n) begin
      res.bad_cell = 1'b1;
      return res;
    end
    ra = root_of(item.cell_a);
    rb = root_of(item.cell_b);
    if (ra != rb) begin
      if (rank_mem[ra] > rank_mem[rb]) begin
        parent_mem[rb] = ra;
      end else begin
        parent_mem[ra] = rb;
        if (rank_mem[ra] == rank_mem[rb] && rank_mem[rb] < RANK_MAX) begin
          rank_mem[rb] = rank_mem[rb] + 1'b1;
        end
      end
      res.removed = 1'b1;
    end
    return res;
  endfunction

  task automatic log_mismatch(input string why, input out_t want, input out_t got);
    errs++;
    if (errs <= 10) begin
      $display("%0t: %s on result %0d: expected echo=%0d removed=%0b bad=%0b,",
               $time, why, checked, want.wall_echo, want.removed, want.bad_cell);
      $display("    got echo=%0d removed=%0b bad=%0b",
               got.wall_echo, got.removed, got.bad_cell);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_sets(CELLS);
      cells_used = CELL_COUNT_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        cells_used = cfg_wdata;
      end
      // a result and a new transfer may share an edge: retire the old one first
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          log_mismatch("unexpected result", '0, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.wall_echo !== want.wall_echo || out_data.removed !== want.removed ||
              out_data.bad_cell !== want.bad_cell) begin
            log_mismatch("field mismatch", want, out_data);
          end
        end
        checked++;
      end
      if (start && !busy) begin
        expected_results.push_back(predict_merge(in_data));
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* dv/union_find_wall_merger_tb.sv */
// union_find_wall_merger_tb: drives wall and start items and cell count writes
// into the union-find wall merger and gives the verdict from ufwm_checker.
// Depends on ufwm_pkg, union_find_wall_merger and ufwm_checker.
module union_find_wall_merger_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ufwm_pkg::*;

  localparam int RANDOM_ITEMS = 1100;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_t              in_data   = '0;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending;

  int walls_sent = 0;
  int starts_sent = 0;
  int cfg_writes = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  union_find_wall_merger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ufwm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_t wall_item(input int id, input int a, input int b);
    in_t it;
    it.kind    = KIND_WALL;
    it.wall_id = WALL_W'(id);
    it.cell_a  = CELL_W'(a);
    it.cell_b  = CELL_W'(b);
    return it;
  endfunction

  // the other fields carry noise so that a zero echo is really checked
  function automatic in_t start_item();
    in_t it;
    it.kind    = KIND_START;
    it.wall_id = WALL_W'($urandom);
    it.cell_a  = CELL_W'($urandom);
    it.cell_b  = CELL_W'($urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // called at a clock edge; returns at the edge where the transfer happens
  task automatic offer(input in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    if (it.kind == KIND_START) starts_sent++;
    else walls_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cell_count(input int value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int sent;
    int cnt;
    int n;
    int len;
    int w;
    int r;
    int a;
    int b;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // directed: full size after reset, edge indexes, same cell twice
    offer(wall_item(2047, 0, 1023));
    offer(wall_item(0, 0, 0));
    offer(wall_item(1, 1023, 0));
    offer(wall_item(1365, 682, 341));
    offer(wall_item(682, 341, 682));
    offer(start_item());
    offer(wall_item(5, 0, 1023));
    // no cells in use: everything flagged, start clears nothing
    set_cell_count(0);
    offer(wall_item(7, 0, 0));
    offer(start_item());
    // count above the array size is clipped
    set_cell_count(2047);
    offer(wall_item(100, 1023, 1));
    set_cell_count(1);
    offer(start_item());
    offer(wall_item(3, 0, 0));
    offer(wall_item(4, 0, 1));
    offer(wall_item(6, 1, 0));
    set_cell_count(2);
    offer(start_item());
    offer(wall_item(8, 0, 1));
    offer(wall_item(9, 1, 0));
    // count changed without a start keeps the old sets
    set_cell_count(1024);
    offer(wall_item(10, 1, 1023));
    set_cell_count(3);
    offer(wall_item(11, 2, 3));
    offer(wall_item(12, 0, 2));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) cnt = 0;
      else if (r < 9) cnt = 1;
      else if (r < 15) cnt = $urandom_range(1025, 2047);
      else if (r < 20) cnt = (r < 17) ? 2047 : 1024;
      else if (r < 26) cnt = $urandom_range(1000, 1024);
      else if (r < 36) cnt = $urandom_range(65, 300);
      else cnt = $urandom_range(2, 64);
      set_cell_count(cnt);
      n = (cnt < CELLS) ? cnt : CELLS;
      w = $urandom_range(1, 32);
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0) begin
        offer(start_item());
        sent++;
      end
      len = $urandom_range(10, 60);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (n == 0 || r >= 95) begin
          a = $urandom_range(0, 1023);
          b = $urandom_range(0, 1023);
        end else if (r < 75) begin
          // grid neighbors with some random pairs mixed in
          a = $urandom_range(0, n - 1);
          case ($urandom_range(0, 2))
            0: b = (a + 1 < n) ? a + 1 : $urandom_range(0, n - 1);
            1: b = (a + w < n) ? a + w : $urandom_range(0, n - 1);
            default: b = $urandom_range(0, n - 1);
          endcase
          if ($urandom_range(0, 1) == 1) begin
            r = a;
            a = b;
            b = r;
          end
        end else if (r < 85) begin
          a = $urandom_range(0, n - 1);
          b = a;
        end else if (n < CELLS) begin
          a = $urandom_range(n, 1023);
          b = $urandom_range(0, 1023);
          if ($urandom_range(0, 1) == 1) begin
            r = a;
            a = b;
            b = r;
          end
        end else begin
          a = $urandom_range(0, 1023);
          b = $urandom_range(0, 1023);
        end
        offer(wall_item($urandom_range(0, 2047), a, b));
        sent++;
        r = $urandom_range(0, 99);
        if (r < 2) begin
          offer(start_item());
          sent++;
        end else if (r < 4) begin
          settle();
        end
      end
    end

    settle();
    repeat (64) @(posedge clk);
    $display("covered %0d wall items and %0d maze starts over %0d cell count writes",
             walls_sent, starts_sent, cfg_writes);
    if (pending != 0) $display("results never shown: %0d", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
